### rtl/core/mesh_router_dimension_order_core_assert.svh
// Assertion macros shared by the router core.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef MESH_ROUTER_DIMENSION_ORDER_CORE_ASSERT_SVH
`define MESH_ROUTER_DIMENSION_ORDER_CORE_ASSERT_SVH

// same-cycle implication
`define MRDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mrdo_pkg.sv
package mrdo_pkg;

    localparam int MAX_PORTS = 4;
    localparam int CMDQ_DEPTH = 2;
    localparam logic [2:0] LOCAL_PORT_CODE = 3'd4;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_SEND   = 1'b1
    } t_cmd_kind;

    typedef enum logic [2:0] {
        CFG_ROUTER_ID  = 3'd0,
        CFG_PORT_DIR_0 = 3'd1,
        CFG_PORT_DIR_1 = 3'd2,
        CFG_PORT_DIR_2 = 3'd3,
        CFG_PORT_DIR_3 = 3'd4
    } t_cfg_index;

    // opcode in the lowest bits, same layout as the stream words
    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  ypos;
        logic [7:0]  xpos;
        logic [7:0]  receiver;
        logic [7:0]  sender;
        logic [7:0]  tag;
        logic [7:0]  opcode;
    } t_packet;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   to_local;
        logic [MAX_PORTS-1:0]   port_mask;
        t_packet                pkt;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_EMIT
    } t_back_state;

endpackage

### rtl/core/mrdo_front.sv
module mrdo_front #(
    parameter int PORTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,
    input  logic [0:0]          s_axis_tuser,
    input  mrdo_pkg::t_q_status i_q_status,
    output logic                o_push,
    output mrdo_pkg::t_cmd      o_cmd
);
    import mrdo_pkg::*;

    logic [7:0] r_router_id;
    t_dir       r_port_dir [MAX_PORTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_id <= 8'd0;
            for (int i = 0; i < MAX_PORTS; i++) begin
                r_port_dir[i] <= t_dir'(2'(i));
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ROUTER_ID:  r_router_id   <= i_cfg_data;
                CFG_PORT_DIR_0: r_port_dir[0] <= t_dir'(i_cfg_data[1:0]);
                CFG_PORT_DIR_1: r_port_dir[1] <= t_dir'(i_cfg_data[1:0]);
                CFG_PORT_DIR_2: r_port_dir[2] <= t_dir'(i_cfg_data[1:0]);
                CFG_PORT_DIR_3: r_port_dir[3] <= t_dir'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    t_packet   pkt;
    t_cmd_kind kind;
    t_dir      dir;
    logic      to_local;
    logic      drop;

    // row first, then column
    always_comb begin
        pkt      = t_packet'(s_axis_tdata);
        kind     = t_cmd_kind'(s_axis_tuser[0]);
        to_local = (pkt.receiver == r_router_id);
        if (pkt.receiver[3:0] > r_router_id[3:0]) begin
            dir = DIR_DOWN;
        end else if (pkt.receiver[3:0] < r_router_id[3:0]) begin
            dir = DIR_UP;
        end else if (pkt.receiver[7:4] > r_router_id[7:4]) begin
            dir = DIR_RIGHT;
        end else begin
            dir = DIR_LEFT;
        end
        drop = (kind == CMD_PACKET) && (pkt.opcode == 8'd0);

        o_cmd.kind      = kind;
        o_cmd.pkt       = pkt;
        o_cmd.to_local  = (kind == CMD_PACKET) && to_local;
        o_cmd.port_mask = '0;
        for (int q = 0; q < MAX_PORTS; q++) begin
            if (q < PORTS) begin
                o_cmd.port_mask[q] = (kind == CMD_PACKET) && !to_local
                                     && (r_port_dir[q] == dir);
            end
        end
    end

    assign s_axis_tready = !i_q_status.full;
    assign o_push        = s_axis_tvalid && !i_q_status.full && !drop;

endmodule

### rtl/core/mrdo_cmd_queue.sv
module mrdo_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mrdo_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output mrdo_pkg::t_cmd      o_cmd,
    output mrdo_pkg::t_q_status o_status
);
    import mrdo_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_slot [CMDQ_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_status.full  = (r_count == CW'(CMDQ_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_cmd          = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/mrdo_back.sv
module mrdo_back #(
    parameter int PORTS        = 4,
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrdo_pkg::t_cmd      i_cmd,
    input  mrdo_pkg::t_q_status i_q_status,
    output logic                o_q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,
    output logic [3:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    import mrdo_pkg::*;

    localparam int NQ   = PORTS + 1;
    localparam int QW   = $clog2(NQ);
    localparam int AW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW   = $clog2(BUFFER_DEPTH + 1);
    localparam int SUMW = FW + 1;

    t_back_state   r_state;
    t_back_state   n_state;
    logic [QW-1:0] r_step;
    logic [QW-1:0] sel_q;
    logic          do_push;
    logic          emit_fire;
    logic          last_step;

    logic [FW-1:0] w_fill [NQ];
    t_packet       w_rd   [NQ];

    logic          r_out_valid;
    t_packet       r_out_pkt;
    logic [2:0]    r_out_port;
    logic          r_out_hit;
    logic          r_out_last;

    assign sel_q     = (r_step == '0) ? QW'(PORTS) : r_step - 1'b1;
    assign last_step = (r_step == QW'(PORTS));

    // per-FIFO storage; the read register follows the head every cycle
    for (genvar g = 0; g < NQ; g++) begin : g_fifo
        t_packet         r_mem [BUFFER_DEPTH];
        logic [FW-1:0]   r_fill;
        logic [AW-1:0]   r_head;
        t_packet         r_rd;
        logic            sel;
        logic            push_en;
        logic            pop_en;
        logic [SUMW-1:0] sum;
        logic [AW-1:0]   tail;

        if (g == PORTS) begin : g_local
            assign sel = i_cmd.to_local;
        end else begin : g_mesh
            assign sel = i_cmd.port_mask[g];
        end

        assign push_en = do_push && sel && (r_fill != FW'(BUFFER_DEPTH));
        assign pop_en  = emit_fire && (sel_q == QW'(g)) && (r_fill != '0);
        assign sum     = SUMW'(r_head) + SUMW'(r_fill);
        assign tail    = (sum >= SUMW'(BUFFER_DEPTH)) ? AW'(sum - SUMW'(BUFFER_DEPTH))
                                                      : AW'(sum);

        always_ff @(posedge i_clk) begin
            if (push_en) begin
                r_mem[tail] <= i_cmd.pkt;
            end
            r_rd <= r_mem[r_head];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fill <= '0;
                r_head <= '0;
            end else if (push_en) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop_en) begin
                r_fill <= r_fill - 1'b1;
                r_head <= (r_head == AW'(BUFFER_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
        end

        assign w_fill[g] = r_fill;
        assign w_rd[g]   = r_rd;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty && (i_cmd.kind == CMD_SEND)) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: n_state = BK_EMIT;
            BK_EMIT: begin
                if (emit_fire && last_step) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        do_push   = 1'b0;
        emit_fire = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_q_pop = !i_q_status.empty;
                do_push = !i_q_status.empty && (i_cmd.kind == CMD_PACKET);
            end
            BK_EMIT: emit_fire = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_LOAD) begin
                r_step <= '0;
            end else if (emit_fire) begin
                r_step <= r_step + 1'b1;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_hit  <= (w_fill[sel_q] != '0);
            r_out_pkt  <= (w_fill[sel_q] != '0) ? w_rd[sel_q] : '0;
            r_out_port <= (r_step == '0) ? LOCAL_PORT_CODE : 3'(sel_q);
            r_out_last <= last_step;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pkt;
    assign m_axis_tuser  = {r_out_hit, r_out_port};
    assign m_axis_tlast  = r_out_last;

endmodule

### rtl/core/mesh_router_dimension_order_core.sv
// channel   handshake                        payload
// s_axis    s_axis_tvalid / s_axis_tready    tdata: packet, tuser: command
// m_axis    m_axis_tvalid / m_axis_tready    tdata: packet, tuser: port+hit, tlast
// cfg       i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// Input words land in a two-entry command queue; one word per cycle while it has room.
// Back end: a packet word is popped and written into all matching FIFOs in parallel;
// a send tick is a dequeue, a FIFO read state (BK_LOAD), then PORTS+1 results.
// Results leave through one output register; a stalled m_axis holds the sequencer.
// Synchronous active-low reset clears FIFO counts, pointers and control; no clearing pass.
`include "mesh_router_dimension_order_core_assert.svh"

module mesh_router_dimension_order_core #(
    parameter int PORTS        = 4,
    parameter int BUFFER_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, packet_tag, sender, receiver, xpos, ypos, color[15:0]
    input  logic [63:0] s_axis_tdata,
    // command
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_opcode, out_tag, out_sender, out_receiver, out_xpos, out_ypos, out_color[15:0]
    output logic [63:0] m_axis_tdata,
    // out_port[2:0], out_valid
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import mrdo_pkg::*;

    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    assign o_cfg_ready = 1'b1;

    mrdo_front #(
        .PORTS (PORTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (q_status),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    mrdo_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    mrdo_back #(
        .PORTS        (PORTS),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_q_status    (q_status),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // an empty FIFO reports an all-zero word
    `MRDO_ASSERT_IMP(a_empty_word_zero, m_axis_tvalid && !m_axis_tuser[3], m_axis_tdata == 64'd0, "empty result carries data")
    // empty packets are never stored, so a popped word has a nonzero opcode
    `MRDO_ASSERT_IMP(a_popped_opcode, m_axis_tvalid && m_axis_tuser[3], m_axis_tdata[7:0] != 8'd0, "popped word with zero opcode")
    // the last result of a tick belongs to the highest mesh port
    `MRDO_ASSERT_IMP(a_last_port, m_axis_tvalid && m_axis_tlast, m_axis_tuser[2:0] == 3'(PORTS - 1), "tlast on wrong port")
    // results of one tick follow without gaps
    `MRDO_ASSERT_NEXT(a_tick_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a send tick")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import mrdo_pkg::*;

    localparam int NUM_PORTS   = 4;
    localparam int DEPTH       = 8;
    localparam int LOCAL_Q     = NUM_PORTS;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_WORDS = 70;

    typedef struct {
        t_cmd_kind kind;
        t_packet   pkt;
        bit        drain_first;
    } t_in_word;

    typedef struct {
        logic [2:0] port;
        logic       hit;
        t_packet    pkt;
        logic       last;
    } t_out_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // opcode, tag, sender, receiver, xpos, ypos, color
    logic [0:0]  s_axis_tuser = '0;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;          // opcode, tag, sender, receiver, xpos, ypos, color
    logic [3:0]  m_axis_tuser;          // port[2:0], hit
    logic        m_axis_tlast;

    always #4 i_clk = ~i_clk;

    mesh_router_dimension_order_core #(
        .PORTS        (NUM_PORTS),
        .BUFFER_DEPTH (DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // router state as seen by the predictor
    logic [7:0] router_id = 8'h00;
    t_dir       port_dir [NUM_PORTS] = '{DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT};
    t_packet    store [NUM_PORTS+1][DEPTH];
    int         fill [NUM_PORTS+1] = '{default: 0};
    int         head [NUM_PORTS+1] = '{default: 0};

    t_in_word   tx_words[$];
    t_out_word  due_results[$];
    t_in_word   in_flight;

    int  errors = 0;
    int  n_packets = 0, n_sends = 0, n_empty = 0, n_results = 0;
    int  n_full_drops = 0, n_unrouted = 0, n_settings = 0;
    int  stall_cycles = 0;
    bit  drained = 1'b1;
    bit  timed_out = 1'b0;

    int  src_gap = 0, src_run = 0, snk_gap = 0, snk_run = 0;
    bit  src_calm = 1'b0, snk_calm = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic void fifo_push(input int q, input t_packet p);
        if (fill[q] >= DEPTH) begin
            n_full_drops++;
        end else begin
            store[q][(head[q] + fill[q]) % DEPTH] = p;
            fill[q]++;
        end
    endfunction

    // row first: down/up by the low nibble, then right/left by the high nibble
    function automatic void route_packet(input t_packet p);
        t_dir way;
        bit   served;
        served = 1'b0;
        if (p.opcode == 8'h00) begin
            n_empty++;
            return;
        end
        n_packets++;
        if (p.receiver == router_id) begin
            fifo_push(LOCAL_Q, p);
            return;
        end
        if (p.receiver[3:0] > router_id[3:0])
            way = DIR_DOWN;
        else if (p.receiver[3:0] < router_id[3:0])
            way = DIR_UP;
        else if (p.receiver[7:4] > router_id[7:4])
            way = DIR_RIGHT;
        else
            way = DIR_LEFT;
        for (int q = 0; q < NUM_PORTS; q++) begin
            if (port_dir[q] == way) begin
                fifo_push(q, p);
                served = 1'b1;
            end
        end
        if (!served)
            n_unrouted++;
    endfunction

    // one word per queue: local first, then mesh ports in order
    function automatic void pop_all_fifos();
        t_out_word r;
        int        q;
        n_sends++;
        for (int k = 0; k <= NUM_PORTS; k++) begin
            q = (k == 0) ? LOCAL_Q : k - 1;
            r.port = (q == LOCAL_Q) ? LOCAL_PORT_CODE : q[2:0];
            r.hit  = (fill[q] != 0);
            r.pkt  = '0;
            if (r.hit) begin
                r.pkt   = store[q][head[q]];
                head[q] = (head[q] + 1) % DEPTH;
                fill[q]--;
            end
            r.last = (k == NUM_PORTS);
            due_results.push_back(r);
        end
    endfunction

    function automatic void push_packet(input logic [7:0] op, input logic [7:0] tag,
                                        input logic [7:0] recv, input logic [7:0] fb);
        t_in_word w;
        w.kind        = CMD_PACKET;
        w.pkt         = '{color: {fb, ~fb}, ypos: fb, xpos: ~fb, receiver: recv,
                          sender: fb, tag: tag, opcode: op};
        w.drain_first = 1'b0;
        tx_words.push_back(w);
    endfunction

    function automatic void push_send();
        t_in_word w;
        w.kind        = CMD_SEND;
        w.pkt         = {$urandom, $urandom};
        w.drain_first = 1'b0;
        tx_words.push_back(w);
    endfunction

    // destinations lean toward this router, its row and its column
    function automatic t_in_word random_word(input int send_pct);
        t_in_word w;
        int       r;
        w.pkt         = {$urandom, $urandom};
        w.drain_first = 1'b0;
        w.kind        = ($urandom_range(99) < send_pct) ? CMD_SEND : CMD_PACKET;
        r = $urandom_range(99);
        if (r < 15)
            w.pkt.receiver = router_id;
        else if (r < 35)
            w.pkt.receiver = {4'($urandom), router_id[3:0]};
        else if (r < 50)
            w.pkt.receiver = {router_id[7:4], 4'($urandom)};
        if ($urandom_range(99) < 8)
            w.pkt.opcode = 8'h00;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROUTER_ID)
            router_id = val;
        else
            port_dir[int'(idx) - int'(CFG_PORT_DIR_0)] = t_dir'(val[1:0]);
    endtask

    task automatic program_router(input logic [7:0] id, input t_dir d0, input t_dir d1,
                                  input t_dir d2, input t_dir d3);
        t_dir       dirs [NUM_PORTS];
        logic [5:0] junk;
        dirs = '{d0, d1, d2, d3};
        n_settings++;
        write_reg(CFG_ROUTER_ID, id);
        for (int i = 0; i < NUM_PORTS; i++) begin
            junk = 6'($urandom);
            write_reg(t_cfg_index'(int'(CFG_PORT_DIR_0) + i), {junk, dirs[i]});
        end
    endtask

    // everything sent, every result back, then room for the command queue to settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tx_words.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (16) @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        drained <= (due_results.size() == 0);

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (in_flight.kind == CMD_SEND)
                    pop_all_fifos();
                else
                    route_packet(in_flight.pkt);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_run == 0) begin
                    src_calm = ($urandom_range(3) == 0);
                    src_run  = $urandom_range(20, 80);
                end else begin
                    src_run--;
                end
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tx_words.size() == 0 ||
                             (tx_words[0].drain_first && (s_axis_tvalid || !drained))) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!src_calm && $urandom_range(3) == 0) begin
                    src_gap = pick_gap() - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    in_flight = tx_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.pkt;
                    s_axis_tuser  <= in_flight.kind;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_word want;
        t_packet   got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_results++;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got tuser %0h tdata %0h last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = due_results.pop_front();
                check_field("port", 16'(want.port), 16'(m_axis_tuser[2:0]));
                check_field("hit", 16'(want.hit), 16'(m_axis_tuser[3]));
                check_field("opcode", 16'(want.pkt.opcode), 16'(got.opcode));
                check_field("tag", 16'(want.pkt.tag), 16'(got.tag));
                check_field("sender", 16'(want.pkt.sender), 16'(got.sender));
                check_field("receiver", 16'(want.pkt.receiver), 16'(got.receiver));
                check_field("xpos", 16'(want.pkt.xpos), 16'(got.xpos));
                check_field("ypos", 16'(want.pkt.ypos), 16'(got.ypos));
                check_field("color", want.pkt.color, got.color);
                check_field("last", 16'(want.last), 16'(m_axis_tlast));
            end
        end
        if (snk_run == 0) begin
            snk_calm = ($urandom_range(3) == 0);
            snk_run  = $urandom_range(20, 80);
        end else begin
            snk_run--;
        end
        if (snk_gap != 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else if (!snk_calm && $urandom_range(3) == 0) begin
            snk_gap = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        fork
            begin
                repeat (6) @(posedge i_clk);
                i_rst_n <= 1'b1;

                // default directions, at least one word to each direction and to self
                program_router(8'h55, DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT);
                @(negedge i_clk);
                push_send();
                push_packet(8'h00, 8'h11, 8'h55, 8'h5A);
                push_packet(8'hFF, 8'hFF, 8'h55, 8'hFF);
                push_packet(8'h01, 8'h00, 8'h57, 8'h00);
                push_packet(8'h80, 8'h02, 8'h32, 8'hA5);
                push_packet(8'h7F, 8'h03, 8'h75, 8'h3C);
                push_packet(8'h42, 8'h04, 8'h35, 8'hC3);
                push_packet(8'h99, 8'h05, 8'hFF, 8'h0F);
                push_packet(8'h66, 8'h06, 8'h00, 8'hF0);
                push_send();
                push_send();
                // overfill the down queue: last one is lost
                for (int i = 0; i < DEPTH + 1; i++)
                    push_packet(8'(8'h20 + i), 8'(8'h40 + i), 8'h5A, 8'(8'h10 * i));
                push_send();
                wait_idle();

                // two ports share down, nobody serves up
                program_router(8'hA3, DIR_DOWN, DIR_DOWN, DIR_LEFT, DIR_RIGHT);
                @(negedge i_clk);
                push_packet(8'h31, 8'h70, 8'hA7, 8'h77);
                push_packet(8'h32, 8'h71, 8'hA1, 8'h88);
                push_packet(8'h33, 8'h72, 8'hAC, 8'h99);
                push_packet(8'h34, 8'h73, 8'hF3, 8'hEE);
                push_send();
                wait_idle();

                for (int ph = 0; ph < 6; ph++) begin
                    case (ph)
                        0: program_router(8'h00, DIR_RIGHT, DIR_UP, DIR_DOWN, DIR_UP);
                        1: program_router(8'hFF, DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN);
                        2: program_router(8'($urandom), DIR_UP, DIR_LEFT, DIR_RIGHT, DIR_DOWN);
                        default: program_router(8'($urandom), t_dir'($urandom_range(3)),
                                                t_dir'($urandom_range(3)),
                                                t_dir'($urandom_range(3)),
                                                t_dir'($urandom_range(3)));
                    endcase
                    @(negedge i_clk);
                    for (int n = 0; n < PHASE_WORDS; n++) begin
                        tx_words.push_back(random_word((ph == 1) ? 10 :
                                                       (ph == 2) ? 40 : 15 + 5 * ph));
                        tx_words[$].drain_first = (n == PHASE_WORDS / 2) ||
                                                  ($urandom_range(99) < 2);
                    end
                    wait_idle();
                end
            end
            begin
                do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
                timed_out = 1'b1;
                $display("%0t: watchdog expired, %0d results still due", $time,
                         due_results.size());
            end
        join_any

        $display("covered %0d routed packets, %0d empty packets, %0d send ticks, %0d results",
                 n_packets, n_empty, n_sends, n_results);
        $display("over %0d router settings; drops on full queues %0d, with no serving port %0d",
                 n_settings, n_full_drops, n_unrouted);
        if (!timed_out && errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mrdo_pkg.sv
rtl/core/mrdo_front.sv
rtl/core/mrdo_cmd_queue.sv
rtl/core/mrdo_back.sv
rtl/core/mesh_router_dimension_order_core.sv
verif/tb.sv
